// ----- src/neville_polynomial_interpolator_core_defines.svh -----
// Assertion macros shared by the checker of the Neville interpolator core.
// Depends on nothing; included by the checker file.
`ifndef NEVILLE_POLYNOMIAL_INTERPOLATOR_CORE_DEFINES_SVH
`define NEVILLE_POLYNOMIAL_INTERPOLATOR_CORE_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define NPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define NPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/npi_pkg.sv -----
// Package of the Neville interpolator core: constants, status codes, sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
package npi_pkg;
	localparam int MaxPointsDefault = 16;
	localparam int FracBitsDefault = 16;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SAME_X = 2'd1,
		ST_DROPPED = 2'd2
	} npi_status_t;

	typedef enum logic [3:0] {
		S_LOAD, S_SCAN_RD, S_SCAN, S_LVL, S_RD, S_DIV_GO, S_DIV_WAIT,
		S_MUL_LO, S_MUL_HI, S_WR, S_PICK, S_PICK_RD, S_PICK_ADD, S_OUT
	} npi_state_t;

	// Saturate a 64-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ----- src/npi_divider.sv -----
// Restoring unsigned-magnitude divider, one quotient bit a cycle, saturating signed result.
// Depends on npi_pkg.
`timescale 1ns / 1ps
module npi_divider import npi_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] num,
	input  logic signed [33:0] den,
	output logic               done,
	output logic signed [31:0] quot
);
	localparam int NW = 33 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [NW-1:0] quo_q;
	logic [33:0]   rem_q;
	logic [32:0]   dsr_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [33:0]   trial;
	logic [33:0]   shifted;
	logic [32:0]   an, ad;

	assign an = num[33] ? 33'(-num) : num[32:0];
	assign ad = den[33] ? 33'(-den) : den[32:0];
	assign shifted = {rem_q[32:0], dvd_q[NW-1]};
	assign trial = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {an, {FRAC_BITS{1'b0}}};
			dsr_q <= ad;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= num[33] ^ den[33];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!trial[33]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) quot = (quo_q >= NW'(64'h80000000)) ? 32'sh80000000 : 32'(-quo_q);
		else quot = (quo_q >= NW'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : quo_q[31:0];
	end
endmodule

// ----- src/npi_multiplier.sv -----
// Registered signed-magnitude multiplier, 33 by 32 bits, shifted and saturated.
// Depends on npi_pkg.
`timescale 1ns / 1ps
module npi_multiplier import npi_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic               clk,
	input  logic signed [33:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] prod
);
	logic [32:0] am;
	logic [31:0] bm;
	logic [64:0] p_s1;
	logic        neg_s1;
	logic [64:0] sh;

	assign am = a[33] ? 33'(-a) : a[32:0];
	assign bm = b[31] ? 32'(-b) : 32'(b);

	always_ff @(posedge clk) begin
		p_s1 <= 65'(am) * 65'(bm);
		neg_s1 <= a[33] ^ b[31];
	end

	assign sh = p_s1 >> FRAC_BITS;
	always_comb begin
		if (neg_s1) prod = (sh >= 65'h80000000) ? 32'sh80000000 : 32'(-sh);
		else prod = (sh >= 65'h7FFFFFFF) ? 32'sh7FFFFFFF : sh[31:0];
	end
endmodule

// ----- src/neville_polynomial_interpolator_core.sv -----
// Top level of the Neville interpolator: point memories, sequencer, shared divider and multiplier.
// Depends on npi_pkg, npi_divider, npi_multiplier.
//
// Channel | Signals                                         | Direction
// in      | in_valid, in_stall, point_x/y, query_x, last_point | into block
// out     | out_valid, out_stall, value, error_estimate, status | out of block
//
// A point that is not last is only stored. A last item with n stored points starts a
// nearest-point scan, then n*(n-1)/2 tableau steps, each with its reads, a pass through
// the shared serial divider, two multiplier passes and the write-back, and a pick of the
// correction at each level before the result. The block holds in_stall high from a last
// item until its result has left. Reset clears the point count and the overflow flag;
// the memories need no clearing pass.
`timescale 1ns / 1ps
module neville_polynomial_interpolator_core import npi_pkg::*; #(
	parameter int MAX_POINTS = MaxPointsDefault,
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] query_x,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic signed [31:0] error_estimate,
	output logic [1:0]         status
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic signed [31:0] xs_mem [MAX_POINTS];
	logic signed [31:0] ys_mem [MAX_POINTS];
	logic signed [31:0] up_mem [MAX_POINTS];
	logic signed [31:0] lo_mem [MAX_POINTS];

	npi_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic signed [31:0] qx_q;
	logic [AW-1:0] j_q, pos_q, lvl_q;
	logic [32:0]   best_q;
	logic signed [31:0] acc_q, corr_q;
	logic signed [31:0] xl_q, xh_q, uu_q, ll_q;
	logic signed [31:0] qt_q, lo_new_q;
	logic          same_q;

	logic accept;
	logic div_start, div_done;
	logic signed [31:0] div_quot, mul_prod;
	logic signed [33:0] gl, gh, mul_a;
	logic [CW-1:0] lvl_ext, j_ext;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign lvl_ext = CW'(lvl_q);
	assign j_ext = CW'(j_q);
	assign gl = 34'(xl_q) - 34'(qx_q);
	assign gh = 34'(xh_q) - 34'(qx_q);
	assign div_start = (state_q == S_DIV_GO) && (gl != gh);
	assign mul_a = (state_q == S_MUL_LO) ? gh : gl;

	npi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(34'(uu_q) - 34'(ll_q)), .den(gl - gh),
		.done(div_done), .quot(div_quot)
	);

	npi_multiplier #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .a(mul_a), .b(qt_q), .prod(mul_prod)
	);

	// Memory writes: point load, column fill during scan, corrections per step.
	always_ff @(posedge clk) begin
		if (accept && cnt_q < CW'(MAX_POINTS)) begin
			xs_mem[cnt_q[AW-1:0]] <= point_x;
			ys_mem[cnt_q[AW-1:0]] <= point_y;
		end
		if (state_q == S_SCAN_RD) begin
			up_mem[j_q] <= ys_mem[j_q];
			lo_mem[j_q] <= ys_mem[j_q];
		end
		if (state_q == S_WR) begin
			lo_mem[j_q] <= lo_new_q;
			up_mem[j_q] <= mul_prod;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_SCAN_RD: xl_q <= xs_mem[j_q];
			S_RD: begin
				xl_q <= xs_mem[j_q];
				xh_q <= xs_mem[AW'(j_ext + lvl_ext)];
				uu_q <= up_mem[AW'(j_ext + 1'b1)];
				ll_q <= lo_mem[j_q];
			end
			S_PICK_RD: uu_q <= (CW'({pos_q, 1'b0}) < cnt_q - lvl_ext) ?
				up_mem[pos_q] : lo_mem[AW'(pos_q - 1'b1)];
			default: ;
		endcase
		if (div_done) qt_q <= div_quot;
		if (state_q == S_MUL_HI) lo_new_q <= mul_prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (cnt_q < CW'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (state_q == S_OUT && !out_stall) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// Working registers of the evaluation.
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= query_x;
			j_q <= '0;
			same_q <= 1'b0;
			corr_q <= '0;
		end
		case (state_q)
			S_SCAN: begin
				if (j_q == '0 || 33'(gl[33] ? -gl : gl) < best_q) begin
					best_q <= 33'(gl[33] ? -gl : gl);
					pos_q <= j_q;
				end
				j_q <= j_q + 1'b1;
			end
			S_LVL: begin
				if (lvl_q == '0) acc_q <= ys_mem[pos_q];
				j_q <= '0;
				lvl_q <= lvl_q + 1'b1;
			end
			S_DIV_GO: if (gl == gh) same_q <= 1'b1;
			S_WR: j_q <= j_q + 1'b1;
			S_PICK_RD: if (!(CW'({pos_q, 1'b0}) < cnt_q - lvl_ext)) pos_q <= pos_q - 1'b1;
			S_PICK_ADD: begin
				corr_q <= uu_q;
				acc_q <= sat32(64'(acc_q) + 64'(uu_q));
			end
			default: ;
		endcase
		if (state_q == S_SCAN && j_ext + 1'b1 == cnt_q) lvl_q <= '0;
	end

	always_comb begin
		state_d = state_q;
		value = acc_q;
		error_estimate = corr_q;
		status = ovf_q ? ST_DROPPED : ST_OK;
		if (same_q) begin
			value = '0;
			error_estimate = '0;
			status = ST_SAME_X;
		end else if (cnt_q == '0) begin
			value = '0;
			error_estimate = '0;
		end
		case (state_q)
			S_LOAD: if (accept && last_point) begin
				if (cnt_q == '0 && ovf_q) state_d = S_OUT;
				else if (cnt_q == '0 && !(cnt_q < CW'(MAX_POINTS))) state_d = S_OUT;
				else state_d = S_SCAN_RD;
			end
			S_SCAN_RD: state_d = S_SCAN;
			S_SCAN: state_d = (j_ext + 1'b1 == cnt_q) ? S_LVL : S_SCAN_RD;
			S_LVL: state_d = (lvl_ext + 1'b1 < cnt_q) ? S_RD : S_OUT;
			S_RD: state_d = S_DIV_GO;
			S_DIV_GO: state_d = (gl == gh) ? S_OUT : S_DIV_WAIT;
			S_DIV_WAIT: if (div_done) state_d = S_MUL_LO;
			S_MUL_LO: state_d = S_MUL_HI;
			S_MUL_HI: state_d = S_WR;
			S_WR: state_d = (j_ext + lvl_ext + 1'b1 < cnt_q) ? S_RD : S_PICK;
			S_PICK: state_d = S_PICK_RD;
			S_PICK_RD: state_d = S_PICK_ADD;
			S_PICK_ADD: state_d = S_LVL;
			S_OUT: if (!out_stall) state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end
endmodule

// ----- src/npi_checker.sv -----
// Port-level checker of the Neville interpolator core, bound to the top level.
// Depends on npi_pkg and the core defines header.
`timescale 1ns / 1ps
`include "neville_polynomial_interpolator_core_defines.svh"
module npi_checker import npi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_point,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] value,
	input logic [1:0]  status
);
	`NPI_ASSERT_IMP(a_status_code, clk, arst_n, out_valid, status != 2'd3, "bad status code")
	`NPI_ASSERT_IMP(a_no_take_while_out, clk, arst_n, out_valid, in_stall, "input taken during output")
	`NPI_ASSERT_NEXT(a_last_blocks, clk, arst_n, in_valid && !in_stall && last_point, in_stall, "no stall after last item")
	`NPI_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(value), "stalled result changed")
	`NPI_ASSERT_IMP(a_same_zero, clk, arst_n, out_valid && status == ST_SAME_X, value == '0, "nonzero value on duplicate abscissae")
endmodule

bind neville_polynomial_interpolator_core npi_checker u_npi_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.last_point(last_point), .out_valid(out_valid), .out_stall(out_stall),
	.value(value), .status(status)
);
